// File: hw/rtl/crf_pkg.sv
// Shared types, widths and codes for the checkpoint ring FIFO.
package crf_pkg;

  localparam int unsigned DEPTH      = 8 * 1024;
  localparam int unsigned ENTRY_BITS = 64;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned RES_W      = 14;
  localparam int unsigned LVL_W      = 13;
  localparam int unsigned OCC_W      = 13;
  localparam int unsigned FREE_W     = 14;
  localparam int unsigned CMP_W      = (PTR_W + 1 > RES_W) ? PTR_W + 1 : RES_W;
  localparam int unsigned CFG_W      = 14;

  localparam logic [RES_W-1:0] RESERVE_RST = RES_W'(100);
  localparam logic [LVL_W-1:0] LEVEL_RST   = LVL_W'(10);
  localparam logic [RES_W-1:0] RESERVE_MIN = RES_W'(2);

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_SAVE  = 3'd2,
    CMD_REWIND = 3'd3,
    CMD_ARM   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_MISUSE   = 2'd3
  } status_e;

  // Bit positions of the wake-up conditions, same as the wait_kind codes
  localparam int unsigned WK_NOT_EMPTY = 0;
  localparam int unsigned WK_EMPTY     = 1;
  localparam int unsigned WK_ALMOST    = 2;
  localparam int unsigned WK_SPACE     = 3;

  typedef enum logic [0:0] {
    CFG_SPACE_RESERVE = 1'b0,
    CFG_ALMOST_LEVEL  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
    logic [PTR_W-1:0] saved_rp;
    logic             saved_on;
  } crf_ptrs_t;

  typedef struct packed {
    logic [PTR_W-1:0] occ;
    logic [PTR_W:0]   free;
    logic             push_ok;
    logic [3:0]       conds;
  } crf_view_t;

endpackage

// File: hw/rtl/crf_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module crf_ram #(
  parameter int unsigned DEPTH_P = 16,
  parameter int unsigned WIDTH_P = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH_P)-1:0] waddr_i,
  input  logic [WIDTH_P-1:0]         wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_i,
  output logic [WIDTH_P-1:0]         rdata_o
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/crf_cond.sv
// Occupancy, free space, push threshold and wake-up conditions from the pointers.
module crf_cond (
  input  crf_pkg::crf_ptrs_t         ptrs_i,
  input  logic [crf_pkg::RES_W-1:0]  reserve_i,
  input  logic [crf_pkg::LVL_W-1:0]  level_i,
  output crf_pkg::crf_view_t         view_o
);
  import crf_pkg::*;

  logic [PTR_W-1:0] limit;
  logic [PTR_W-1:0] gap;
  logic [RES_W-1:0] need;

  always_comb begin
    limit = ptrs_i.saved_on ? ptrs_i.saved_rp : ptrs_i.rp;
    view_o.occ = ptrs_i.wp - ptrs_i.rp;
    // equal pointers mean the whole ring is free
    gap = limit - ptrs_i.wp - PTR_W'(1);
    view_o.free = {1'b0, gap} + (PTR_W + 1)'(1);
    need = (reserve_i < RESERVE_MIN) ? RESERVE_MIN : reserve_i;
    view_o.push_ok = CMP_W'(view_o.free) >= CMP_W'(need);
    view_o.conds = '0;
    view_o.conds[WK_NOT_EMPTY] = view_o.occ != '0;
    view_o.conds[WK_EMPTY]     = (view_o.occ == '0) && !ptrs_i.saved_on;
    view_o.conds[WK_ALMOST]    = (CMP_W'(view_o.occ) <= CMP_W'(level_i))
                                 && !ptrs_i.saved_on;
    view_o.conds[WK_SPACE]     = view_o.push_ok;
  end

endmodule

// File: hw/rtl/checkpoint_ring_fifo.sv
// Checkpoint ring FIFO top level: command sequencer, pointers and entry RAM.
// For every command, in the accept cycle the entry RAM is written
// (push) or read (pop) and the pointers are updated; in the next cycle the
// result beat is shown with result_valid_o high for that one cycle, pop data
// coming straight from the RAM's registered read port. busy is high during
// the result cycle, and no new command is taken while busy is high. The
// receiver cannot stall: the result beat must be captured when it appears.
// Status, wake-up signals, occupancy and free space describe the state after
// the command. Configuration may be written while busy is low and no command
// is being started in the same cycle.
module checkpoint_ring_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  crf_pkg::cfg_reg_e           cfg_idx_i,
  input  logic [crf_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd_i,
  input  logic [1:0]                  wait_kind_i,
  input  logic [crf_pkg::DATA_W-1:0]  push_data_i,
  output logic                        result_valid_o,
  output logic [crf_pkg::DATA_W-1:0]  pop_data_o,
  output logic [1:0]                  status_o,
  output logic [3:0]                  signals_o,
  output logic [crf_pkg::OCC_W-1:0]   occupancy_o,
  output logic [crf_pkg::FREE_W-1:0]  free_space_o,
  output logic                        checkpoint_on_o
);
  import crf_pkg::*;

  state_e            state_q, state_d;
  crf_ptrs_t         ptrs_q, ptrs_d;
  logic [3:0]        armed_q, armed_d;
  status_e           status_q, status_d;
  logic              pop_ok_q, pop_ok_d;
  logic [RES_W-1:0]  reserve_q;
  logic [LVL_W-1:0]  level_q;
  crf_view_t         view;
  logic              accept;
  logic              ram_we, ram_re;
  logic [3:0]        fired;
  logic [ENTRY_BITS-1:0] rd_data;

  crf_cond u_cond (
    .ptrs_i    (ptrs_q),
    .reserve_i (reserve_q),
    .level_i   (level_q),
    .view_o    (view)
  );

  // Push and pop never touch the RAM in the same cycle, and a pop reads an
  // entry at least one command after its push: no forwarding needed.
  crf_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (ENTRY_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptrs_q.wp),
    .wdata_i (push_data_i[ENTRY_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (ptrs_q.rp),
    .rdata_o (rd_data)
  );

  assign accept = start && (state_q == ST_IDLE);
  assign fired  = armed_q & view.conds;

  always_comb begin
    state_d  = state_q;
    ptrs_d   = ptrs_q;
    armed_d  = armed_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_RESP;
          status_d = STAT_OK;
          pop_ok_d = 1'b0;
          unique case (cmd_i)
            CMD_PUSH: begin
              if (view.push_ok) begin
                ram_we    = 1'b1;
                ptrs_d.wp = ptrs_q.wp + PTR_W'(1);
              end else begin
                status_d = STAT_NO_SPACE;
              end
            end
            CMD_POP: begin
              if (view.occ == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                ram_re    = 1'b1;
                pop_ok_d  = 1'b1;
                ptrs_d.rp = ptrs_q.rp + PTR_W'(1);
              end
            end
            CMD_SAVE: begin
              if (ptrs_q.saved_on) begin
                status_d = STAT_MISUSE;
              end else begin
                ptrs_d.saved_rp = ptrs_q.rp;
                ptrs_d.saved_on = 1'b1;
              end
            end
            CMD_REWIND: begin
              if (!ptrs_q.saved_on) begin
                status_d = STAT_MISUSE;
              end else begin
                ptrs_d.rp       = ptrs_q.saved_rp;
                ptrs_d.saved_rp = '0;
                ptrs_d.saved_on = 1'b0;
              end
            end
            CMD_ARM: begin
              armed_d[wait_kind_i] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        // conditions seen on this beat fire once and disarm
        state_d = ST_IDLE;
        armed_d = armed_q & ~fired;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ptrs_q    <= '0;
      armed_q   <= '0;
      status_q  <= STAT_OK;
      pop_ok_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptrs_q    <= ptrs_d;
      armed_q   <= armed_d;
      status_q  <= status_d;
      pop_ok_q  <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserve_q <= RESERVE_RST;
      level_q   <= LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPACE_RESERVE: reserve_q <= cfg_data_i[RES_W-1:0];
        CFG_ALMOST_LEVEL:  level_q   <= cfg_data_i[LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy            = (state_q == ST_RESP);
  assign result_valid_o  = (state_q == ST_RESP);
  assign pop_data_o      = pop_ok_q ? DATA_W'(rd_data) : '0;
  assign status_o        = status_q;
  assign signals_o       = fired;
  assign occupancy_o     = OCC_W'(view.occ);
  assign free_space_o    = FREE_W'(view.free);
  assign checkpoint_on_o = ptrs_q.saved_on;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> result_valid_o)
    else $error("accepted command produced no result beat");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat lasted more than one cycle");

  a_refused_push_keeps_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == STAT_NO_SPACE) |-> ptrs_q.wp == $past(ptrs_q.wp))
    else $error("refused push moved the write pointer");

  a_fired_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (armed_q & $past(signals_o)) == '0)
    else $error("fired condition stayed armed");

  a_ring_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> view.free != '0)
    else $error("free space reached zero");

endmodule
